FILE: src/char_lcd_nibble_sequencer_macros.svh
// Assertion macros for the character LCD nibble sequencer.
// Included by the modules that check their own logic; needs clock and reset in scope.
`ifndef CHAR_LCD_NIBBLE_SEQUENCER_MACROS_SVH
`define CHAR_LCD_NIBBLE_SEQUENCER_MACROS_SVH

// Check that a condition implies a consequence in the same cycle.
`define CLNS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define CLNS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/clns_pkg.sv
// Package for the character LCD nibble sequencer: request codes, job and transfer
// types, queue sizing and the initialise transfer table. No dependencies.
package clns_pkg;

   localparam int LINE_LENGTH = 40;
   localparam logic [5:0] COL_MAX = 6'(LINE_LENGTH - 1);

   localparam logic [1:0] REQ_WRITE_CHAR = 2'd0;
   localparam logic [1:0] REQ_SET_CURSOR = 2'd1;
   localparam logic [1:0] REQ_CLEAR      = 2'd2;
   localparam logic [1:0] REQ_INIT       = 2'd3;

   localparam logic [7:0] ROW0_BASE        = 8'h80;
   localparam logic [7:0] ROW1_BASE        = 8'hC0;
   localparam logic [7:0] CMD_FUNCTION_SET = 8'h28;
   localparam logic [7:0] CMD_DISPLAY_ON   = 8'h0C;
   localparam logic [7:0] CMD_ENTRY_MODE   = 8'h06;
   localparam logic [7:0] CMD_CLEAR        = 8'h01;

   localparam logic [1:0] CLEAR_WAIT_MS = 2'd2;

   localparam int STEP_W = 4;
   localparam logic [STEP_W-1:0] INIT_LAST_STEP = 4'd11;
   localparam logic [STEP_W-1:0] BYTE_LAST_STEP = 4'd1;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = QPTR_W + 1;

   typedef struct packed {
      logic       is_init;
      logic       rs;
      logic [7:0] byte_val;
      logic [1:0] wait_after;
   } job_type;

   typedef struct packed {
      logic       rs;
      logic [3:0] nibble;
      logic [3:0] wait_before;
      logic [1:0] wait_after;
      logic       last;
   } xfer_type;

   function automatic xfer_type init_xfer(input logic [STEP_W-1:0] step);
      xfer_type x;
      x = '0;
      unique case (step)
         4'd0: begin
            x.nibble = 4'h3;
            x.wait_before = 4'd15;
         end
         4'd1: begin
            x.nibble = 4'h3;
            x.wait_before = 4'd5;
         end
         4'd2: begin
            x.nibble = 4'h3;
            x.wait_before = 4'd5;
         end
         4'd3: begin
            x.nibble = 4'h2;
            x.wait_before = 4'd5;
         end
         4'd4:  x.nibble = CMD_FUNCTION_SET[7:4];
         4'd5:  x.nibble = CMD_FUNCTION_SET[3:0];
         4'd6:  x.nibble = CMD_DISPLAY_ON[7:4];
         4'd7:  x.nibble = CMD_DISPLAY_ON[3:0];
         4'd8:  x.nibble = CMD_ENTRY_MODE[7:4];
         4'd9:  x.nibble = CMD_ENTRY_MODE[3:0];
         4'd10: x.nibble = CMD_CLEAR[7:4];
         4'd11: begin
            x.nibble = CMD_CLEAR[3:0];
            x.wait_after = CLEAR_WAIT_MS;
            x.last = 1'b1;
         end
         default: x = '0;
      endcase
      return x;
   endfunction

endpackage

FILE: src/char_lcd_nibble_sequencer.sv
// Character LCD nibble sequencer, 4-bit bus controller front end (top level).
// Instantiates clns_front, clns_queue and clns_back; depends on clns_pkg.
//
// Usage:
//   Request channel (req_*): one item per request - write character, set cursor,
//   clear display or initialise. A string goes in as one write-character item per
//   character. req_stall rises while the four-entry job queue is full.
//   Result channel (rsp_*): one item per nibble transfer, high nibble first, with
//   RS level, waits before and after the strobe, and rsp_last on the final
//   transfer of each request. The downstream enable-strobe driver paces the pins.
//   Each accepted request is written into the job queue, and its first transfer is
//   loaded into the output register once the job is at the queue head. Throughput:
//   one transfer per cycle while rsp_stall is low; a write-char, set-cursor or clear
//   request yields two transfers, initialise twelve, walked by the head job's step counter.
//   Requests are taken while earlier jobs are still being expanded.
//   When rsp_stall is high the output register holds its transfer and the step
//   counter stops; the queue keeps absorbing requests until it fills.
//   Reset (synchronous, active high) empties the queue and drops any pending transfer.
module char_lcd_nibble_sequencer (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_type,
   input  logic [7:0] req_char_code,
   input  logic [5:0] req_column,
   input  logic       req_row,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_register_select,
   output logic [3:0] rsp_nibble,
   output logic [3:0] rsp_wait_before_ms,
   output logic [1:0] rsp_wait_after_ms,
   output logic       rsp_last
);
   import clns_pkg::*;

   logic    queue_full;
   logic    push;
   job_type push_job;
   logic    pop;
   logic    head_valid;
   job_type head_job;

   clns_front u_front (
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_type      (req_type),
      .req_char_code (req_char_code),
      .req_column    (req_column),
      .req_row       (req_row),
      .queue_full    (queue_full),
      .push          (push),
      .push_job      (push_job)
   );

   clns_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .pop        (pop),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   clns_back u_back (
      .clock               (clock),
      .reset               (reset),
      .head_valid          (head_valid),
      .head_job            (head_job),
      .pop                 (pop),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_register_select (rsp_register_select),
      .rsp_nibble          (rsp_nibble),
      .rsp_wait_before_ms  (rsp_wait_before_ms),
      .rsp_wait_after_ms   (rsp_wait_after_ms),
      .rsp_last            (rsp_last)
   );

endmodule

FILE: src/clns_front.sv
// Front part of the nibble sequencer: accepts requests and classifies them into jobs.
// Depends on clns_pkg.
module clns_front (
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_type,
   input  logic [7:0]        req_char_code,
   input  logic [5:0]        req_column,
   input  logic              req_row,
   input  logic              queue_full,
   output logic              push,
   output clns_pkg::job_type push_job
);
   import clns_pkg::*;

   logic [5:0] col_sat;
   logic [7:0] row_base;

   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;
   assign col_sat   = (req_column > COL_MAX) ? COL_MAX : req_column;
   assign row_base  = req_row ? ROW1_BASE : ROW0_BASE;

   always_comb begin
      push_job = '0;
      unique case (req_type)
         REQ_WRITE_CHAR: begin
            push_job.rs       = 1'b1;
            push_job.byte_val = req_char_code;
         end
         REQ_SET_CURSOR: begin
            push_job.byte_val = row_base + {2'b00, col_sat};
         end
         REQ_CLEAR: begin
            push_job.byte_val   = CMD_CLEAR;
            push_job.wait_after = CLEAR_WAIT_MS;
         end
         REQ_INIT: begin
            push_job.is_init = 1'b1;
         end
         default: push_job = '0;
      endcase
   end

endmodule

FILE: src/clns_queue.sv
// Short job queue between the front and back parts of the nibble sequencer.
// Depends on clns_pkg and char_lcd_nibble_sequencer_macros.svh.
`include "char_lcd_nibble_sequencer_macros.svh"
module clns_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  clns_pkg::job_type push_job,
   input  logic              pop,
   output logic              full,
   output logic              head_valid,
   output clns_pkg::job_type head_job
);
   import clns_pkg::*;

   job_type           entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   `CLNS_ASSERT_NOW(a_count_bound, 1'b1, count_ff <= QCNT_W'(QUEUE_DEPTH), "queue count overflow")
   `CLNS_ASSERT_NOW(a_pop_nonempty, pop, head_valid, "pop from empty queue")
   `CLNS_ASSERT_NEXT(a_count_grows, push && !pop, count_ff == $past(count_ff) + QCNT_W'(1), "queue count did not advance on push")

endmodule

FILE: src/clns_back.sv
// Back part of the nibble sequencer: steps through the head job and drives the
// registered transfer outputs. Depends on clns_pkg and the assertion macro header.
`include "char_lcd_nibble_sequencer_macros.svh"
module clns_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  clns_pkg::job_type head_job,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_register_select,
   output logic [3:0]        rsp_nibble,
   output logic [3:0]        rsp_wait_before_ms,
   output logic [1:0]        rsp_wait_after_ms,
   output logic              rsp_last
);
   import clns_pkg::*;

   logic [STEP_W-1:0] step_ff, step_in;
   logic              rsp_valid_ff, rsp_valid_in;
   xfer_type          xfer_ff, xfer_in;
   xfer_type          cur_xfer;
   logic              step_last;
   logic              advance;
   logic              emit;

   assign step_last = head_job.is_init ? (step_ff == INIT_LAST_STEP)
                                       : (step_ff == BYTE_LAST_STEP);
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign emit      = head_valid && advance;
   assign pop       = emit && step_last;

   always_comb begin
      if (head_job.is_init) begin
         cur_xfer = init_xfer(step_ff);
      end else begin
         cur_xfer.rs          = head_job.rs;
         cur_xfer.nibble      = (step_ff == '0) ? head_job.byte_val[7:4]
                                                : head_job.byte_val[3:0];
         cur_xfer.wait_before = '0;
         cur_xfer.wait_after  = (step_ff == '0) ? 2'd0 : head_job.wait_after;
         cur_xfer.last        = step_last;
      end
   end

   always_comb begin
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff;
      xfer_in      = xfer_ff;
      if (emit) begin
         step_in      = step_last ? '0 : step_ff + STEP_W'(1);
         rsp_valid_in = 1'b1;
         xfer_in      = cur_xfer;
      end else if (advance) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      xfer_ff <= xfer_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_register_select = xfer_ff.rs;
   assign rsp_nibble          = xfer_ff.nibble;
   assign rsp_wait_before_ms  = xfer_ff.wait_before;
   assign rsp_wait_after_ms   = xfer_ff.wait_after;
   assign rsp_last            = xfer_ff.last;

   `CLNS_ASSERT_NOW(a_step_bound, 1'b1, step_ff <= INIT_LAST_STEP, "step counter out of range")
   `CLNS_ASSERT_NOW(a_mid_job_head, step_ff != '0, head_valid, "job left mid sequence")
   `CLNS_ASSERT_NEXT(a_hold, rsp_valid && rsp_stall, rsp_valid && $stable(xfer_ff), "not held")

endmodule

FILE: sim/testbench.sv
// Self-checking testbench for char_lcd_nibble_sequencer: requests in, nibble transfers out.
// Predicts every transfer of each accepted request and compares it field by field.
// Depends on clns_pkg and the RTL under src only.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import clns_pkg::*;

   localparam logic [3:0] WAKE_NIBBLE     = 4'h3;
   localparam logic [3:0] BUS_4BIT_NIBBLE = 4'h2;
   localparam logic [3:0] WAKE_FIRST_MS   = 4'd15;
   localparam logic [3:0] WAKE_NEXT_MS    = 4'd5;
   localparam int         IDLE_LIMIT      = 2000;
   localparam int         DRAIN_CYCLES    = 20;

   typedef struct {
      logic [1:0] kind;
      logic [7:0] char_code;
      logic [5:0] column;
      logic       row;
   } lcd_request;

   typedef struct {
      logic       rs;
      logic [3:0] nibble;
      logic [3:0] wait_before;
      logic [1:0] wait_after;
      logic       last;
   } nibble_xfer;

   logic       clock;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [1:0] req_type = REQ_WRITE_CHAR;
   logic [7:0] req_char_code = 8'h00;
   logic [5:0] req_column = 6'd0;
   logic       req_row = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_register_select;
   logic [3:0] rsp_nibble;
   logic [3:0] rsp_wait_before_ms;
   logic [1:0] rsp_wait_after_ms;
   logic       rsp_last;

   lcd_request request_queue[$];
   nibble_xfer lcd_expected[$];
   int         error_count = 0;
   int         idle_cycles = 0;
   int         send_gap = 0;
   int         stall_left = 0;
   logic       req_fire = 1'b0;
   logic       quiet = 1'b0;

   char_lcd_nibble_sequencer uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_type(req_type),
      .req_char_code(req_char_code),
      .req_column(req_column),
      .req_row(req_row),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_register_select(rsp_register_select),
      .rsp_nibble(rsp_nibble),
      .rsp_wait_before_ms(rsp_wait_before_ms),
      .rsp_wait_after_ms(rsp_wait_after_ms),
      .rsp_last(rsp_last)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   task automatic flag_mismatch(input string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      error_count++;
   endtask

   function automatic nibble_xfer make_xfer(input logic rs, input logic [3:0] nib,
                                            input logic [3:0] wb, input logic [1:0] wa);
      nibble_xfer x;
      x.rs = rs;
      x.nibble = nib;
      x.wait_before = wb;
      x.wait_after = wa;
      x.last = 1'b0;
      return x;
   endfunction

   task automatic add_byte(ref nibble_xfer seq[$], input logic rs, input logic [7:0] value,
                           input logic [1:0] wa);
      seq.push_back(make_xfer(rs, value[7:4], 4'd0, 2'd0));
      seq.push_back(make_xfer(rs, value[3:0], 4'd0, wa));
   endtask

   task automatic predict_transfers(input lcd_request r);
      nibble_xfer seq[$];
      logic [5:0] col;
      logic [7:0] cmd;
      case (r.kind)
         REQ_WRITE_CHAR: add_byte(seq, 1'b1, r.char_code, 2'd0);
         REQ_SET_CURSOR: begin
            col = (r.column > COL_MAX) ? COL_MAX : r.column;
            cmd = (r.row ? ROW1_BASE : ROW0_BASE) + {2'b00, col};
            add_byte(seq, 1'b0, cmd, 2'd0);
         end
         REQ_CLEAR: add_byte(seq, 1'b0, CMD_CLEAR, CLEAR_WAIT_MS);
         REQ_INIT: begin
            seq.push_back(make_xfer(1'b0, WAKE_NIBBLE, WAKE_FIRST_MS, 2'd0));
            seq.push_back(make_xfer(1'b0, WAKE_NIBBLE, WAKE_NEXT_MS, 2'd0));
            seq.push_back(make_xfer(1'b0, WAKE_NIBBLE, WAKE_NEXT_MS, 2'd0));
            seq.push_back(make_xfer(1'b0, BUS_4BIT_NIBBLE, WAKE_NEXT_MS, 2'd0));
            add_byte(seq, 1'b0, CMD_FUNCTION_SET, 2'd0);
            add_byte(seq, 1'b0, CMD_DISPLAY_ON, 2'd0);
            add_byte(seq, 1'b0, CMD_ENTRY_MODE, 2'd0);
            add_byte(seq, 1'b0, CMD_CLEAR, CLEAR_WAIT_MS);
         end
      endcase
      seq[seq.size()-1].last = 1'b1;
      foreach (seq[i]) lcd_expected.push_back(seq[i]);
   endtask

   task automatic queue_request(input logic [1:0] kind, input logic [7:0] code,
                                input logic [5:0] col, input logic row);
      lcd_request r;
      r.kind = kind;
      r.char_code = code;
      r.column = col;
      r.row = row;
      request_queue.push_back(r);
   endtask

   function automatic logic [5:0] pick_column();
      if ($urandom_range(0, 4) == 0) return 6'($urandom_range(40, 63));
      return 6'($urandom_range(0, 39));
   endfunction

   function automatic logic [7:0] pick_char();
      if ($urandom_range(0, 3) == 0) return 8'($urandom);
      return 8'($urandom_range(8'h20, 8'h7E));
   endfunction

   // Mostly cursor moves followed by short strings, with clears, inits and noise mixed in.
   task automatic queue_random(input int count);
      int added;
      int pick;
      int len;
      added = 0;
      while (added < count) begin
         pick = $urandom_range(0, 19);
         if (pick < 13) begin
            queue_request(REQ_SET_CURSOR, 8'($urandom), pick_column(), 1'($urandom));
            len = $urandom_range(1, 10);
            for (int i = 0; i < len; i++)
               queue_request(REQ_WRITE_CHAR, pick_char(), 6'($urandom), 1'($urandom));
            added += len + 1;
         end else if (pick < 16) begin
            queue_request(REQ_CLEAR, 8'($urandom), 6'($urandom), 1'($urandom));
            added++;
         end else if (pick < 17) begin
            queue_request(REQ_INIT, 8'($urandom), 6'($urandom), 1'($urandom));
            added++;
         end else begin
            queue_request(2'($urandom), 8'($urandom), 6'($urandom), 1'($urandom));
            added++;
         end
      end
   endtask

   task automatic wait_all_done();
      while (request_queue.size() != 0 || req_valid || lcd_expected.size() != 0)
         @(posedge clock);
   endtask

   always @(negedge clock) begin
      lcd_request r;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_valid <= 1'b0;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            send_gap <= $urandom_range(0, 18);
            req_valid <= 1'b0;
         end else if (request_queue.size() != 0) begin
            r = request_queue.pop_front();
            req_type <= r.kind;
            req_char_code <= r.char_code;
            req_column <= r.column;
            req_row <= r.row;
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
         stall_left <= $urandom_range(0, 18);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      nibble_xfer want;
      lcd_request taken;
      req_fire <= !reset && req_valid && !req_stall;
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (lcd_expected.size() == 0) begin
               flag_mismatch($sformatf("transfer with nothing expected, nibble %h", rsp_nibble));
            end else begin
               want = lcd_expected.pop_front();
               if (rsp_register_select !== want.rs)
                  flag_mismatch($sformatf("register_select %b, want %b",
                                          rsp_register_select, want.rs));
               if (rsp_nibble !== want.nibble)
                  flag_mismatch($sformatf("nibble %h, want %h", rsp_nibble, want.nibble));
               if (rsp_wait_before_ms !== want.wait_before)
                  flag_mismatch($sformatf("wait_before_ms %0d, want %0d",
                                          rsp_wait_before_ms, want.wait_before));
               if (rsp_wait_after_ms !== want.wait_after)
                  flag_mismatch($sformatf("wait_after_ms %0d, want %0d",
                                          rsp_wait_after_ms, want.wait_after));
               if (rsp_last !== want.last)
                  flag_mismatch($sformatf("last %b, want %b", rsp_last, want.last));
            end
         end
         if (req_valid && !req_stall) begin
            taken.kind = req_type;
            taken.char_code = req_char_code;
            taken.column = req_column;
            taken.row = req_row;
            predict_transfers(taken);
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            idle_cycles <= 0;
         end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   initial begin
      queue_request(REQ_WRITE_CHAR, 8'h00, 6'd0, 1'b0);
      queue_request(REQ_WRITE_CHAR, 8'hFF, 6'd63, 1'b1);
      queue_request(REQ_WRITE_CHAR, 8'h5A, 6'd21, 1'b0);
      queue_request(REQ_WRITE_CHAR, 8'hA5, 6'd42, 1'b1);
      queue_request(REQ_SET_CURSOR, 8'h00, 6'd0, 1'b0);
      queue_request(REQ_SET_CURSOR, 8'hFF, 6'd0, 1'b1);
      queue_request(REQ_SET_CURSOR, 8'h12, 6'd39, 1'b0);
      queue_request(REQ_SET_CURSOR, 8'h34, 6'd39, 1'b1);
      queue_request(REQ_SET_CURSOR, 8'h56, 6'd40, 1'b0);
      queue_request(REQ_SET_CURSOR, 8'h78, 6'd63, 1'b1);
      queue_request(REQ_SET_CURSOR, 8'h9A, 6'd21, 1'b1);
      queue_request(REQ_SET_CURSOR, 8'hBC, 6'd42, 1'b0);
      queue_request(REQ_CLEAR, 8'hFF, 6'd63, 1'b1);
      queue_request(REQ_INIT, 8'h00, 6'd0, 1'b0);
      queue_request(REQ_INIT, 8'hFF, 6'd63, 1'b1);
      queue_request(REQ_CLEAR, 8'h00, 6'd0, 1'b0);
      queue_request(REQ_WRITE_CHAR, 8'h41, 6'd0, 1'b0);
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      wait_all_done();
      queue_random(170);
      wait_all_done();
      queue_random(125);
      while (request_queue.size() != 0) @(posedge clock);
      quiet = 1'b1;
      queue_random(55);
      wait_all_done();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("testbench OK");
      else
         $display("testbench NOT OK");
      $finish;
   end

endmodule
